// ===== hdl/bdlp_pkg.sv =====
// Shared types and constants for the button debounce / long-press unit.
// No dependencies; used by bdlp_lane, bdlp_merge and the top level.
package bdlp_pkg;

  // Width and reset value of the hold (long-press) reload register
  localparam int unsigned HOLD_W = 16;
  localparam logic [HOLD_W-1:0] HOLD_TICKS_RESET = 16'd100;

  // Depth of the per-button sample history
  localparam int unsigned HIST_W = 3;
  localparam logic [HIST_W-1:0] HIST_RELEASED = {HIST_W{1'b1}};
  localparam logic [HIST_W-1:0] HIST_PRESSED  = {HIST_W{1'b0}};

  // Opcodes of the input beat
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Command broadcast to every lane on an accepted input beat
  typedef struct packed {
    logic step;    // input beat accepted this cycle
    logic opcode;  // OP_TICK or OP_READ
  } lane_cmd_t;

  // What one lane reports for the current beat
  typedef struct packed {
    logic press;
    logic long_press;
    logic level;
  } lane_res_t;

endpackage

// ===== hdl/button_debounce_long_press_unit.sv =====
// The result beat appears in the cycle after the input beat is accepted.
// Throughput: one tick or read per cycle unless the output stalls; one lane per
// button; the single output register takes a new beat as the old one is taken.
// Reset (rst, synchronous): buttons released, histories all ones, counters and
// the hold reload value at 100, all flags clear, no output beat pending.
module button_debounce_long_press_unit #(
  parameter int unsigned NUM_BUTTONS = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bdlp_pkg::HOLD_W-1:0] hold_ticks,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        opcode,
  input  logic [NUM_BUTTONS-1:0]      raw_levels,
  input  logic [NUM_BUTTONS-1:0]      clear_press_mask,
  input  logic [NUM_BUTTONS-1:0]      clear_long_mask,
  // output channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [NUM_BUTTONS-1:0]      press_flags,
  output logic [NUM_BUTTONS-1:0]      long_flags,
  output logic [NUM_BUTTONS-1:0]      stable_levels
);

  logic [bdlp_pkg::HOLD_W-1:0] reload_value;
  bdlp_pkg::lane_cmd_t         cmd;
  bdlp_pkg::lane_res_t         lane_res [NUM_BUTTONS];
  logic                        accept;

  // Take a new beat whenever the output register is free or being emptied
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign cmd       = '{step: accept, opcode: opcode};
  assign cfg_ready = 1'b1;

  // Hold the reload register
  always_ff @(posedge clk) begin
    if (rst) begin
      reload_value <= bdlp_pkg::HOLD_TICKS_RESET;
    end else if (cfg_valid) begin
      reload_value <= hold_ticks;
    end
  end

  // One lane per button
  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
    bdlp_lane u_lane (
      .clk          (clk),
      .rst          (rst),
      .cmd          (cmd),
      .raw          (raw_levels[g]),
      .clr_press    (clear_press_mask[g]),
      .clr_long     (clear_long_mask[g]),
      .reload_value (reload_value),
      .res          (lane_res[g])
    );
  end

  bdlp_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk           (clk),
    .rst           (rst),
    .load          (accept),
    .lane_res      (lane_res),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .press_flags   (press_flags),
    .long_flags    (long_flags),
    .stable_levels (stable_levels)
  );

endmodule

// ===== hdl/bdlp_lane.sv =====
// One button lane: sample history, debounced level, hold counter, sticky flags.
// Depends on bdlp_pkg.
module bdlp_lane (
  input  logic                        clk,
  input  logic                        rst,
  input  bdlp_pkg::lane_cmd_t         cmd,
  input  logic                        raw,
  input  logic                        clr_press,
  input  logic                        clr_long,
  input  logic [bdlp_pkg::HOLD_W-1:0] reload_value,
  output bdlp_pkg::lane_res_t         res
);

  logic [bdlp_pkg::HIST_W-1:0] hist, hist_next;
  logic                        level, level_next;
  logic [bdlp_pkg::HOLD_W-1:0] count, count_next, count_dec;
  logic                        press, press_next;
  logic                        long_press, long_next;
  logic                        agree;

  assign hist_next = {hist[bdlp_pkg::HIST_W-2:0], raw};
  assign agree     = (hist_next == bdlp_pkg::HIST_PRESSED) ||
                     (hist_next == bdlp_pkg::HIST_RELEASED);
  assign count_dec = count - 1'b1;

  // Work out the lane's next state for this beat
  always_comb begin
    level_next = level;
    count_next = count;
    press_next = press;
    long_next  = long_press;
    if (cmd.opcode == bdlp_pkg::OP_TICK) begin
      if (agree) begin
        if (hist_next[0] != level) begin
          level_next = hist_next[0];
          if (!hist_next[0]) begin
            press_next = 1'b1;
            count_next = reload_value;
          end
        end else if (count_dec == '0) begin
          count_next = reload_value;
          if (!level) long_next = 1'b1;
        end else begin
          count_next = count_dec;
        end
      end
    end else begin
      if (clr_press) press_next = 1'b0;
      if (clr_long)  long_next  = 1'b0;
    end
  end

  // Tick shows the updated state, read shows the flags before clearing
  always_comb begin
    if (cmd.opcode == bdlp_pkg::OP_TICK) begin
      res = '{press: press_next, long_press: long_next, level: level_next};
    end else begin
      res = '{press: press, long_press: long_press, level: level};
    end
  end

  // Hold state, advance on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      hist       <= bdlp_pkg::HIST_RELEASED;
      level      <= 1'b1;
      count      <= bdlp_pkg::HOLD_TICKS_RESET;
      press      <= 1'b0;
      long_press <= 1'b0;
    end else if (cmd.step) begin
      if (cmd.opcode == bdlp_pkg::OP_TICK) hist <= hist_next;
      level      <= level_next;
      count      <= count_next;
      press      <= press_next;
      long_press <= long_next;
    end
  end

  // A press flag only appears on a sample tick
  a_press_on_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(press) |-> $past(cmd.step && cmd.opcode == bdlp_pkg::OP_TICK))
    else $error("press flag set outside a sample tick");

  // A debounced fall always comes with a press flag
  a_fall_sets_press: assert property (@(posedge clk) disable iff (rst)
    $fell(level) |-> press)
    else $error("debounced press without press flag");

  // A long-press flag only rises while held, on a sample tick
  a_long_while_held: assert property (@(posedge clk) disable iff (rst)
    $rose(long_press) |-> !level && $past(cmd.step && cmd.opcode == bdlp_pkg::OP_TICK))
    else $error("long-press flag set while released or outside a tick");

endmodule

// ===== hdl/bdlp_merge.sv =====
// Merge stage: packs the lane results into flag vectors and holds the output beat.
// Depends on bdlp_pkg.
module bdlp_merge #(
  parameter int unsigned NUM_BUTTONS = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  bdlp_pkg::lane_res_t        lane_res [NUM_BUTTONS],
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [NUM_BUTTONS-1:0]     press_flags,
  output logic [NUM_BUTTONS-1:0]     long_flags,
  output logic [NUM_BUTTONS-1:0]     stable_levels
);

  logic [NUM_BUTTONS-1:0] press_vec, long_vec, level_vec;

  // Gather one bit from each lane
  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      press_vec[i] = lane_res[i].press;
      long_vec[i]  = lane_res[i].long_press;
      level_vec[i] = lane_res[i].level;
    end
  end

  // Output valid: set on load, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      press_flags   <= press_vec;
      long_flags    <= long_vec;
      stable_levels <= level_vec;
    end
  end

  // Every loaded beat is offered on the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("loaded beat not presented");

  // A pending beat is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !load)
    else $error("output beat overwritten while stalled");

  // Valid drops only after the beat was taken
  a_drop_after_take: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(out_ready))
    else $error("output beat dropped without handshake");

endmodule
